// ===== design/tls_sni_filter_rst_injector_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the server-name filter
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TLS_SNI_FILTER_RST_INJECTOR_TOP_DEFINES_SVH
`define TLS_SNI_FILTER_RST_INJECTOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, a, c)
`define ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/tsf_pkg.sv =====
// ---------------------------------------------------------------------------
// Server-name filter package
// Payload types, register indexes and the record passed from parser to
// the reset frame generator.
// ---------------------------------------------------------------------------
package tsf_pkg;
  localparam int FRAME_BYTES = 1024;
  localparam int MAX_NAME_BYTES = 16;
  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam int RST_LEN = 54;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reset_byte;
    logic       reset_end;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0, REG_IDENT = 3'd1, REG_N0_LO = 3'd2, REG_N0_HI = 3'd3,
    REG_N0_LEN = 3'd4, REG_N1_LO = 3'd5, REG_N1_HI = 3'd6, REG_N1_LEN = 3'd7
  } reg_index_t;

  // One queued reset job: everything the generator needs.
  typedef struct packed {
    logic [47:0] server_mac;
    logic [47:0] client_mac;
    logic [31:0] server_ip;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] ident;
  } rst_job_t;
endpackage

// ===== design/tsf_parser.sv =====
// ---------------------------------------------------------------------------
// Frame parser
// Walks the received frame, checks headers and the server name, and posts
// a reset job at the end of a matching frame.
// ---------------------------------------------------------------------------
`include "tls_sni_filter_rst_injector_top_defines.svh"
module tsf_parser import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  in_item_t    in_item,
  input  logic [31:0] target_address,
  input  logic [15:0] ident_value,
  input  logic [127:0] name0,
  input  logic [4:0]  len0,
  input  logic [127:0] name1,
  input  logic [4:0]  len1,
  output logic        job_valid,
  output rst_job_t    job
);
  logic [POS_W-1:0] pos;
  logic [47:0] mac0, mac1;
  logic [31:0] ip0, ip1, tn0, tn1;
  logic [15:0] cport;
  logic        hdr_ok;
  logic [7:0]  sid_len, cip_len, nm_len;
  logic [POS_W+1:0] nm_start;
  logic [1:0]  flags;
  logic [7:0]  b;
  logic [POS_W+1:0] p;
  logic [POS_W+1:0] cip_at, nm_at, nm_end;
  logic        in_range, live, match;
  logic [3:0]  j;
  logic [POS_W+1:0] jw;
  logic [7:0]  e0, e1;
  logic [1:0]  toff;

  assign b = in_item.frame_byte;
  assign p = {2'b00, pos};
  assign live = in_valid && (pos < POS_W'(FRAME_BYTES));
  assign cip_at = (POS_W+2)'(99) + {{(POS_W-6){1'b0}}, sid_len};
  assign nm_at = (POS_W+2)'(112) + {{(POS_W-6){1'b0}}, sid_len}
               + {{(POS_W-6){1'b0}}, cip_len};
  assign nm_end = nm_start + {{(POS_W-6){1'b0}}, nm_len};
  assign in_range = (nm_len != 8'd0) && (p >= nm_start) && (p < nm_end);
  assign jw = p - nm_start;
  assign j = jw[3:0];
  assign e0 = name0[8*j +: 8];
  assign e1 = name1[8*j +: 8];
  // Source address bytes 26..29 are compared most significant octet first.
  assign toff = 2'd1 - pos[1:0];

  // Final decision including this cycle's byte.
  logic        ok_n;
  logic [1:0]  fl_n;
  logic [7:0]  sid_n, cip_n, nl_n;
  logic [POS_W+1:0] ns_n;
  logic [POS_W-1:0] pos_n;
  always_comb begin
    ok_n = hdr_ok; fl_n = flags; sid_n = sid_len; cip_n = cip_len;
    nl_n = nm_len; ns_n = nm_start; pos_n = pos;
    if (live) begin
      pos_n = pos + 1'b1;
      if (p >= 26 && p < 30 && b != target_address[8*toff +: 8])
        ok_n = 1'b0;
      if ((p == 23 && b != 8'h06) || (p == 47 && b != 8'h18) ||
          (p == 54 && b != 8'h16) || (p == 59 && b != 8'h01))
        ok_n = 1'b0;
      if (p == 97) sid_n = b;
      else if (p == cip_at) cip_n = b;
      else if (p == nm_at) begin
        nl_n = b; ns_n = p + 1'b1;
      end else if (in_range) begin
        if (jw >= {{(POS_W-3){1'b0}}, len0} || jw >= MAX_NAME_BYTES || b != e0)
          fl_n[0] = 1'b0;
        if (jw >= {{(POS_W-3){1'b0}}, len1} || jw >= MAX_NAME_BYTES || b != e1)
          fl_n[1] = 1'b0;
      end
    end
    match = ok_n && ({2'b00, pos_n} >= (ns_n + {{(POS_W-6){1'b0}}, nl_n}))
      && (ns_n != '0) &&
      ((len0 != 0 && len0 <= MAX_NAME_BYTES && {3'b0, len0} == nl_n && fl_n[0]) ||
       (len1 != 0 && len1 <= MAX_NAME_BYTES && {3'b0, len1} == nl_n && fl_n[1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; hdr_ok <= 1'b1; sid_len <= '0; cip_len <= '0; nm_len <= '0;
      nm_start <= '0; flags <= 2'b11; job_valid <= 1'b0;
      mac0 <= '0; mac1 <= '0; ip0 <= '0; ip1 <= '0; tn0 <= '0; tn1 <= '0;
      cport <= '0;
    end else begin
      job_valid <= 1'b0;
      if (live) begin
        if (p < 6) mac0 <= {mac0[39:0], b};
        else if (p < 12) mac1 <= {mac1[39:0], b};
        else if (p >= 26 && p < 30) ip0 <= {ip0[23:0], b};
        else if (p >= 30 && p < 34) ip1 <= {ip1[23:0], b};
        else if (p == 34 || p == 35) cport <= {cport[7:0], b};
        else if (p >= 38 && p < 42) tn0 <= {tn0[23:0], b};
        else if (p >= 42 && p < 46) tn1 <= {tn1[23:0], b};
      end
      if (in_valid && in_item.frame_end) begin
        pos <= '0; hdr_ok <= 1'b1; sid_len <= '0; cip_len <= '0; nm_len <= '0;
        nm_start <= '0; flags <= 2'b11;
        job_valid <= match;
      end else begin
        pos <= pos_n; hdr_ok <= ok_n; sid_len <= sid_n; cip_len <= cip_n;
        nm_len <= nl_n; nm_start <= ns_n; flags <= fl_n;
      end
    end
  end

  // Job fields come from the capture registers; the last byte of a frame
  // is far past the captured region, so registering them here is exact.
  always_ff @(posedge clk) begin
    job.server_mac  <= mac0;
    job.client_mac  <= mac1;
    job.server_ip   <= ip1;
    job.client_ip   <= ip0;
    job.client_port <= cport;
    job.seq_num     <= tn1;
    job.ack_num     <= tn0 + 32'd1;
    job.ident       <= ident_value;
  end

  `ASSERT_NXT(a_pos_clear, clk, rst, in_valid && in_item.frame_end, pos == '0)
  `ASSERT_IMP(a_pos_cap, clk, rst, 1'b1, pos <= POS_W'(FRAME_BYTES))
  `ASSERT_NXT(a_job_end, clk, rst, !(in_valid && in_item.frame_end), !job_valid)
endmodule

// ===== design/tsf_queue.sv =====
// ---------------------------------------------------------------------------
// Job queue
// Short FIFO of reset jobs between the parser and the generator.
// ---------------------------------------------------------------------------
module tsf_queue import tsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rst_job_t push_job,
  input  logic     pop,
  output logic     not_empty,
  output logic     has_room,
  output rst_job_t head
);
  rst_job_t mem [QUEUE_DEPTH];
  logic [0:0] wp, rp;
  logic [1:0] cnt;

  assign not_empty = cnt != 2'd0;
  assign has_room = cnt < 2'(QUEUE_DEPTH);
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_job;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== design/tsf_gen.sv =====
// ---------------------------------------------------------------------------
// Reset frame generator
// Computes the checksums of the head job and streams its 54 bytes.
// ---------------------------------------------------------------------------
`include "tls_sni_filter_rst_injector_top_defines.svh"
module tsf_gen import tsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_ready,
  input  rst_job_t  job,
  output logic      job_pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SUM = 3'b010, S_SEND = 3'b100
  } state_t;
  state_t state;
  logic [5:0]  idx;
  logic [15:0] ip_ck, tcp_ck;
  logic [19:0] ip_sum, tcp_sum;
  logic [15:0] f1, f2;

  function automatic logic [15:0] fold(input logic [19:0] s);
    logic [16:0] t;
    logic [15:0] u;
    t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    u = t[15:0] + {15'd0, t[16]};
    return ~u;
  endfunction

  assign f1 = fold(ip_sum);
  assign f2 = fold(tcp_sum);

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      ip_sum <= 20'h4500 + 20'd40 + {4'd0, job.ident} + 20'h8006
        + {4'd0, job.server_ip[31:16]} + {4'd0, job.server_ip[15:0]}
        + {4'd0, job.client_ip[31:16]} + {4'd0, job.client_ip[15:0]};
      tcp_sum <= {4'd0, job.server_ip[31:16]} + {4'd0, job.server_ip[15:0]}
        + {4'd0, job.client_ip[31:16]} + {4'd0, job.client_ip[15:0]}
        + 20'd469 + {4'd0, job.client_port}
        + {4'd0, job.seq_num[31:16]} + {4'd0, job.seq_num[15:0]}
        + {4'd0, job.ack_num[31:16]} + {4'd0, job.ack_num[15:0]}
        + 20'h5014 + 20'hFAF0;
    end
    if (state == S_SUM) begin
      ip_ck <= f1; tcp_ck <= f2;
    end
  end

  logic [7:0] bsel;
  always_comb begin
    case (idx) inside
      [6'd0:6'd5]:   bsel = job.client_mac[8*(5-idx) +: 8];
      [6'd6:6'd11]:  bsel = job.server_mac[8*(11-idx) +: 8];
      6'd12: bsel = 8'h08;
      6'd14: bsel = 8'h45;
      6'd17: bsel = 8'h28;
      6'd18: bsel = job.ident[15:8];
      6'd19: bsel = job.ident[7:0];
      6'd22: bsel = 8'h80;
      6'd23: bsel = 8'h06;
      6'd24: bsel = ip_ck[15:8];
      6'd25: bsel = ip_ck[7:0];
      [6'd26:6'd29]: bsel = job.server_ip[8*(29-idx) +: 8];
      [6'd30:6'd33]: bsel = job.client_ip[8*(33-idx) +: 8];
      6'd34: bsel = 8'h01;
      6'd35: bsel = 8'hBB;
      6'd36: bsel = job.client_port[15:8];
      6'd37: bsel = job.client_port[7:0];
      [6'd38:6'd41]: bsel = job.seq_num[8*(41-idx) +: 8];
      [6'd42:6'd45]: bsel = job.ack_num[8*(45-idx) +: 8];
      6'd46: bsel = 8'h50;
      6'd47: bsel = 8'h14;
      6'd48: bsel = 8'hFA;
      6'd49: bsel = 8'hF0;
      6'd50: bsel = tcp_ck[15:8];
      6'd51: bsel = tcp_ck[7:0];
      default: bsel = 8'h00;
    endcase
  end

  logic load;
  assign load = (state == S_SEND) && (!out_valid || !out_stall);
  assign job_pop = load && (idx == 6'(RST_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; out_valid <= 1'b0;
    end else begin
      // The output register stays full while stalled and refills on a load.
      out_valid <= load || (out_valid && out_stall);
      case (state)
        S_IDLE: if (job_ready) state <= S_SUM;
        S_SUM: state <= S_SEND;
        S_SEND: if (load) begin
          if (idx == 6'(RST_LEN - 1)) begin
            idx <= '0; state <= S_IDLE;
          end else idx <= idx + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.reset_byte <= bsel;
      out_item.reset_end <= idx == 6'(RST_LEN - 1);
    end
  end

  `ASSERT_IMP(a_idx_rng, clk, rst, 1'b1, idx < 6'(RST_LEN))
  `ASSERT_IMP(a_pop_send, clk, rst, job_pop, state == S_SEND && job_ready)
  `ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
endmodule

// ===== design/tls_sni_filter_rst_injector_top.sv =====
// ---------------------------------------------------------------------------
// TLS server-name filter with TCP reset injection
// Watches received frames for a ClientHello to a blocked host and emits a
// 54-byte TCP RST frame toward the client.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  in       | in_valid / in_stall   | in_item  (frame_byte, frame_end)
//  out      | out_valid / out_stall | out_item (reset_byte, reset_end)
//  cfg      | APB psel/penable      | 64-bit registers at 8*index
//
// The front parser takes one frame byte every cycle unless in_stall is high.
// in_stall rises while both queue slots hold reset jobs, and in the cycle
// after the last byte of a matching frame, while its job is written into
// the queue. The back generator forms the checksums (sums in S_IDLE,
// folded in S_SUM) and then sends one byte per cycle as out_stall allows.
// Reset is synchronous; it clears control state and configuration registers.
module tls_sni_filter_rst_injector_top import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [31:0]  target_address;
  logic [15:0]  ident_value;
  logic [127:0] name0, name1;
  logic [4:0]   len0, len1;
  reg_index_t   ridx;

  // Registers sit at eight-byte steps.
  assign ridx = reg_index_t'(paddr[5:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0; ident_value <= '0; name0 <= '0; name1 <= '0;
      len0 <= '0; len1 <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_TARGET: target_address <= pwdata[31:0];
        REG_IDENT:  ident_value <= pwdata[15:0];
        REG_N0_LO:  name0[63:0] <= pwdata;
        REG_N0_HI:  name0[127:64] <= pwdata;
        REG_N0_LEN: len0 <= pwdata[4:0];
        REG_N1_LO:  name1[63:0] <= pwdata;
        REG_N1_HI:  name1[127:64] <= pwdata;
        REG_N1_LEN: len1 <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_TARGET: prdata = {32'd0, target_address};
      REG_IDENT:  prdata = {48'd0, ident_value};
      REG_N0_LO:  prdata = name0[63:0];
      REG_N0_HI:  prdata = name0[127:64];
      REG_N0_LEN: prdata = {59'd0, len0};
      REG_N1_LO:  prdata = name1[63:0];
      REG_N1_HI:  prdata = name1[127:64];
      REG_N1_LEN: prdata = {59'd0, len1};
      default:    prdata = '0;
    endcase
  end

  logic     job_valid, not_empty, has_room, job_pop;
  rst_job_t job, head;
  logic     acc;

  // Stall while a job is being written into the queue, or the queue is full.
  assign in_stall = !has_room || job_valid;
  assign acc = in_valid && !in_stall;

  tsf_parser u_parser (
    .clk, .rst, .in_valid(acc), .in_item, .target_address, .ident_value,
    .name0, .len0, .name1, .len1, .job_valid, .job
  );

  tsf_queue u_queue (
    .clk, .rst, .push(job_valid), .push_job(job), .pop(job_pop),
    .not_empty, .has_room, .head
  );

  tsf_gen u_gen (
    .clk, .rst, .job_ready(not_empty), .job(head), .job_pop,
    .out_valid, .out_item, .out_stall
  );
endmodule

// ===== verif/tls_sni_filter_rst_injector_checker.sv =====
// ----------------------------------------------------------------------------
// Reset frame checker
// Tracks accepted frame bytes, predicts the TCP reset frames the filter must
// send and compares every sent byte against the oldest prediction.
// ----------------------------------------------------------------------------
module tls_sni_filter_rst_injector_checker import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          pending_bytes,
  output int          frames_sent
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] target_addr;
  logic [15:0] ident;
  logic [63:0] name_lo [2];
  logic [63:0] name_hi [2];
  logic [4:0]  name_len [2];

  int unsigned pos;
  logic [47:0] mac_dst, mac_src;
  logic [31:0] cli_ip, srv_ip, ack_in, seq_in;
  logic [15:0] cli_port;
  logic        hdr_ok;
  int unsigned sid_len, cip_len, host_len, host_start;
  logic [1:0]  still_equal;

  out_item_t rst_bytes_q[$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [7:0] entry_byte(input int k, input int unsigned j);
    logic [127:0] nm;
    nm = {name_hi[k], name_lo[k]};
    return nm[8*(j%16) +: 8];
  endfunction

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    while (s[31:16] != 0) s = s[15:0] + s[31:16];
    return ~s[15:0];
  endfunction

  task automatic clear_frame();
    pos = 0; hdr_ok = 1; sid_len = 0; cip_len = 0; host_len = 0;
    host_start = 0; still_equal = 2'b11;
  endtask

  task automatic absorb(input int unsigned p, input logic [7:0] b);
    int unsigned j;
    if (p < 6) mac_dst = {mac_dst[39:0], b};
    else if (p < 12) mac_src = {mac_src[39:0], b};
    else if (p >= 26 && p < 30) begin
      if (b != target_addr[8*(29-p) +: 8]) hdr_ok = 0;
      cli_ip = {cli_ip[23:0], b};
    end else if (p >= 30 && p < 34) srv_ip = {srv_ip[23:0], b};
    else if (p == 34 || p == 35) cli_port = {cli_port[7:0], b};
    else if (p >= 38 && p < 42) ack_in = {ack_in[23:0], b};
    else if (p >= 42 && p < 46) seq_in = {seq_in[23:0], b};
    if ((p == 23 && b != 8'h06) || (p == 47 && b != 8'h18) ||
        (p == 54 && b != 8'h16) || (p == 59 && b != 8'h01)) hdr_ok = 0;
    if (p == 97) sid_len = b;
    else if (p == 99 + sid_len) cip_len = b;
    else if (p == 112 + sid_len + cip_len) begin
      host_len = b;
      host_start = p + 1;
    end else if (host_len != 0 && p >= host_start && p < host_start + host_len) begin
      j = p - host_start;
      for (int k = 0; k < 2; k++)
        if (j >= name_len[k] || j >= MAX_NAME_BYTES || b != entry_byte(k, j))
          still_equal[k] = 0;
    end
  endtask

  function automatic bit blocked_name_seen();
    if (!hdr_ok || pos < 113 + sid_len + cip_len + host_len) return 0;
    for (int k = 0; k < 2; k++)
      if (name_len[k] != 0 && name_len[k] <= MAX_NAME_BYTES &&
          host_len == name_len[k] && still_equal[k]) return 1;
    return 0;
  endfunction

  task automatic queue_reset_frame();
    logic [7:0]  f [RST_LEN];
    logic [31:0] ack, s;
    logic [15:0] ipsum, tcpsum;
    out_item_t   o;
    ack = ack_in + 1;
    s = 32'h4500 + 40 + ident + 32'h8006 + srv_ip[31:16] + srv_ip[15:0] +
        cli_ip[31:16] + cli_ip[15:0];
    ipsum = ones_fold(s);
    s = srv_ip[31:16] + srv_ip[15:0] + cli_ip[31:16] + cli_ip[15:0] + 6 + 20 +
        443 + cli_port + seq_in[31:16] + seq_in[15:0] + ack[31:16] + ack[15:0] +
        32'h5014 + 32'hFAF0;
    tcpsum = ones_fold(s);
    for (int i = 0; i < 6; i++) begin
      f[i] = mac_src[8*(5-i) +: 8];
      f[6+i] = mac_dst[8*(5-i) +: 8];
    end
    {f[12], f[13], f[14], f[15], f[16], f[17]} = 48'h0800_4500_0028;
    {f[18], f[19]} = ident;
    {f[20], f[21], f[22], f[23]} = 32'h0000_8006;
    {f[24], f[25]} = ipsum;
    {f[26], f[27], f[28], f[29]} = srv_ip;
    {f[30], f[31], f[32], f[33]} = cli_ip;
    {f[34], f[35]} = 16'd443;
    {f[36], f[37]} = cli_port;
    {f[38], f[39], f[40], f[41]} = seq_in;
    {f[42], f[43], f[44], f[45]} = ack;
    {f[46], f[47], f[48], f[49]} = 32'h5014_FAF0;
    {f[50], f[51]} = tcpsum;
    {f[52], f[53]} = 16'h0000;
    for (int i = 0; i < RST_LEN; i++) begin
      o.reset_byte = f[i];
      o.reset_end = (i == RST_LEN - 1);
      rst_bytes_q.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      target_addr = 0; ident = 0;
      name_lo[0] = 0; name_lo[1] = 0; name_hi[0] = 0; name_hi[1] = 0;
      name_len[0] = 0; name_len[1] = 0;
      mac_dst = 0; mac_src = 0; cli_ip = 0; srv_ip = 0; ack_in = 0; seq_in = 0;
      cli_port = 0;
      clear_frame();
      rst_bytes_q.delete();
      fail_count = 0;
      frames_sent = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (reg_index_t'(paddr[5:3]))
          REG_TARGET: target_addr = pwdata[31:0];
          REG_IDENT:  ident = pwdata[15:0];
          REG_N0_LO:  name_lo[0] = pwdata;
          REG_N0_HI:  name_hi[0] = pwdata;
          REG_N0_LEN: name_len[0] = pwdata[4:0];
          REG_N1_LO:  name_lo[1] = pwdata;
          REG_N1_HI:  name_hi[1] = pwdata;
          REG_N1_LEN: name_len[1] = pwdata[4:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (rst_bytes_q.size() == 0)
          report_mismatch($sformatf("unexpected reset byte %h", out_item));
        else begin
          want = rst_bytes_q.pop_front();
          if (out_item.reset_byte !== want.reset_byte)
            report_mismatch($sformatf("reset_byte got %h want %h",
                                      out_item.reset_byte, want.reset_byte));
          if (out_item.reset_end !== want.reset_end)
            report_mismatch($sformatf("reset_end got %b want %b",
                                      out_item.reset_end, want.reset_end));
          if (want.reset_end) frames_sent++;
        end
      end
      if (in_valid && !in_stall) begin
        if (pos < FRAME_BYTES) begin
          absorb(pos, in_item.frame_byte);
          pos++;
        end
        if (in_item.frame_end) begin
          if (blocked_name_seen()) queue_reset_frame();
          clear_frame();
        end
      end
    end
    pending_bytes = rst_bytes_q.size();
  end
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Server-name filter testbench
// Writes the blocked names and client address over the register port, sends
// ClientHello frames (blocked, unblocked, malformed, short and long) and lets
// the checker compare the reset frames that come back.
// ----------------------------------------------------------------------------
module testbench import tsf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_item;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [5:0]  paddr = 0;
  logic [63:0] pwdata = 0;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count, pending_bytes, frames_sent;

  // Sender and receiver idling controls. In the closing part no idling occurs.
  bit          idle_enable = 1;
  bit          hold_receiver = 0;

  // The current blocked names, kept here so frames can carry them.
  byte unsigned host_a[$], host_b[$];
  logic [31:0]  client_addr;

  always #6 clk = ~clk;

  tls_sni_filter_rst_injector_top dut (.*);

  tls_sni_filter_rst_injector_checker checker_i (.*);

  // Receiver side: random stall bursts, or a long stall on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_receiver) out_stall <= 1;
      else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(posedge clk);
      end else out_stall <= 0;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [63:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // A name is written as two 64-bit halves with byte 0 lowest.
  task automatic set_name(input bit which, input byte unsigned nm[$], input int len);
    logic [127:0] v = '0;
    foreach (nm[i]) if (i < 16) v[8*i +: 8] = nm[i];
    write_reg(which ? REG_N1_LO : REG_N0_LO, v[63:0]);
    write_reg(which ? REG_N1_HI : REG_N0_HI, v[127:64]);
    write_reg(which ? REG_N1_LEN : REG_N0_LEN, 64'(len));
  endtask

  // One transaction per frame byte; sender gaps occur in random bursts.
  // in_valid stays high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int n;
    if (idle_enable && $urandom_range(0, 15) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= '{frame_byte: b, frame_end: last};
    do @(posedge clk); while (in_stall);
  endtask

  // Drops in_valid after the last accepted byte.
  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_frame(input byte unsigned f[$]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Builds a ClientHello. kind: 0 good, 1 corrupt header byte, 2 truncated in
  // the name, 3 padded past the frame limit.
  task automatic build_hello(output byte unsigned f[$], input byte unsigned nm[$],
                             input int kind);
    int s, c, tail;
    f.delete();
    s = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 32);
    c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(2, 20);
    for (int i = 0; i < 113 + s + c; i++) f.push_back(8'($urandom_range(0, 255)));
    f[23] = 8'h06; f[47] = 8'h18; f[54] = 8'h16; f[59] = 8'h01;
    for (int i = 0; i < 4; i++) f[26+i] = client_addr[8*(3-i) +: 8];
    f[97] = 8'(s); f[99+s] = 8'(c); f[112+s+c] = 8'(nm.size());
    foreach (nm[i]) f.push_back(nm[i]);
    tail = $urandom_range(0, 8);
    repeat (tail) f.push_back(8'($urandom_range(0, 255)));
    case (kind)
      1: begin
        case ($urandom_range(0, 4))
          0: f[23] ^= 8'h01 << $urandom_range(0, 7);
          1: f[47] ^= 8'h01 << $urandom_range(0, 7);
          2: f[54] ^= 8'h01 << $urandom_range(0, 7);
          3: f[59] ^= 8'h01 << $urandom_range(0, 7);
          default: f[26 + $urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
        endcase
      end
      2: while (f.size() > 113 + s + c + nm.size() - 1 && f.size() > 1) void'(f.pop_back());
      3: while (f.size() < FRAME_BYTES + 20) f.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  function automatic void random_name(output byte unsigned nm[$], input int len);
    nm.delete();
    repeat (len) nm.push_back(8'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255)));
  endfunction

  task automatic wait_drained();
    idle_input();
    while (pending_bytes != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Pick the name in a frame: usually a blocked one, sometimes a near miss.
  task automatic pick_name(output byte unsigned nm[$]);
    int r = $urandom_range(0, 9);
    if (r < 4) nm = host_a;
    else if (r < 7) nm = host_b;
    else if (r == 7) begin
      nm = host_a;
      if (nm.size() > 0) nm[$urandom_range(0, nm.size() - 1)] ^= 8'h20;
    end else if (r == 8) begin
      nm = host_b;
      nm.push_back(8'h2e);
    end else random_name(nm, $urandom_range(0, 16));
  endtask

  task automatic config_phase(input int la, input int lb, input bit extreme);
    client_addr = extreme ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
    random_name(host_a, la);
    random_name(host_b, lb);
    write_reg(REG_TARGET, {$urandom, client_addr});
    write_reg(REG_IDENT, extreme ? 64'hFFFF : {$urandom, $urandom});
    set_name(0, host_a, la);
    set_name(1, host_b, lb);
  endtask

  initial begin
    byte unsigned f[$], nm[$];
    int k;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed: extremes, each rejection reason, and the long/short frames.
    config_phase(16, 1, 1);
    nm = host_a; build_hello(f, nm, 0); send_frame(f);
    nm = host_b; build_hello(f, nm, 0); send_frame(f);
    nm = host_a; build_hello(f, nm, 1); send_frame(f);
    nm = host_a; build_hello(f, nm, 2); send_frame(f);
    nm = host_b; build_hello(f, nm, 3); send_frame(f);
    nm = host_a; nm.push_back(8'h00); build_hello(f, nm, 0); send_frame(f);
    send_byte(8'hFF, 1);
    send_byte(8'h00, 1);
    nm = host_a; build_hello(f, nm, 0);
    for (int i = 0; i < 32; i++) f[i] = 8'hFF;
    for (int i = 38; i < 46; i++) f[i] = 8'hFF;
    send_frame(f);
    wait_drained();

    // Disabled entries and an out-of-range length.
    config_phase(0, 17, 0);
    build_hello(f, nm, 0); send_frame(f);
    nm.delete(); build_hello(f, nm, 0); send_frame(f);
    wait_drained();

    // Random phases of frames with varying configuration.
    for (int ph = 0; ph < 5; ph++) begin
      config_phase($urandom_range(1, 16), $urandom_range(0, 16), ph == 4);
      for (int i = 0; i < 18; i++) begin
        pick_name(nm);
        k = $urandom_range(0, 19);
        build_hello(f, nm, k < 15 ? 0 : k < 17 ? 1 : k < 19 ? 2 : 3);
        if ($urandom_range(0, 9) == 0) begin
          f.delete();
          repeat ($urandom_range(1, 150)) f.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(f);
        if (ph == 1 && i == 2) begin
          // Sender pauses until every reset frame has come back.
          idle_input();
          while (pending_bytes != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    // Long receiver hold-off: blocked frames pile up until the input stalls.
    config_phase(8, 12, 0);
    hold_receiver = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_receiver = 0;
      end
    join_none
    for (int i = 0; i < 6; i++) begin
      nm = host_a; build_hello(f, nm, 0); send_frame(f);
    end

    // Closing part with no idling on either side.
    idle_enable = 0;
    idle_input();
    while (hold_receiver) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      pick_name(nm); build_hello(f, nm, 0); send_frame(f);
    end

    idle_input();
    while (pending_bytes != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/tsf_pkg.sv
design/tsf_parser.sv
design/tsf_queue.sv
design/tsf_gen.sv
design/tls_sni_filter_rst_injector_top.sv
verif/tls_sni_filter_rst_injector_checker.sv
verif/testbench.sv
